/* rtl/core/bao_pkg.sv */
// Shared widths, vector types and small helpers for the box axis orthonormalizer.
// Used by bao_norm and by the top level box_axis_orthonormalize_core.
`timescale 1ns / 1ps
package bao_pkg;

   localparam int FRAC_BITS  = 20;
   localparam int IN_W       = 24;
   localparam int UNIT_W     = FRAC_BITS + 2;
   localparam int VEC_W      = 27;
   localparam int MAG_W      = VEC_W;
   localparam int NORM_BIT   = 30;
   localparam int POS_W      = $clog2(NORM_BIT + 1);
   localparam int SH_W       = NORM_BIT + 1;
   localparam int SQ_W       = 2 * SH_W;
   localparam int SUM_W      = 64;
   localparam int ROOT_W     = 32;
   localparam int SQ_STG     = ROOT_W / 2;
   localparam int SQ_REM_W   = ROOT_W + 4;
   localparam int QUO_W      = FRAC_BITS + 2;
   localparam int NUM_W      = SH_W + FRAC_BITS + 1;
   localparam int DREM_W     = ROOT_W + 1;
   localparam int PROD_W     = 2 * VEC_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int NORM_LAT   = 3 + (SQ_STG + 1) + (QUO_W + 1) + 1;
   localparam int XLAT       = 4;
   localparam int SIDE_DEPTH = 3 * NORM_LAT + 2 * XLAT;

   typedef logic [2:0][VEC_W-1:0]  vec_type;
   typedef logic [2:0][UNIT_W-1:0] unit_type;
   typedef logic [2:0][IN_W-1:0]   in_vec_type;
   typedef logic [2:0][SH_W-1:0]   shv_type;

   typedef struct packed {
      in_vec_type a2;
      in_vec_type a3;
      unit_type   u1;
      unit_type   u3;
      logic       deg;
   } side_type;

   function automatic logic [VEC_W-1:0] ext_in(input logic [IN_W-1:0] v);
      return {{(VEC_W - IN_W){v[IN_W-1]}}, v};
   endfunction

   function automatic logic [VEC_W-1:0] ext_unit(input logic [UNIT_W-1:0] v);
      return {{(VEC_W - UNIT_W){v[UNIT_W-1]}}, v};
   endfunction

   // Position of the highest set bit; zero for an all-zero word.
   function automatic logic [POS_W-1:0] lead_pos(input logic [MAG_W-1:0] v);
      logic [POS_W-1:0] p;
      p = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (v[b]) p = POS_W'(b);
      end
      return p;
   endfunction

endpackage

/* rtl/core/bao_norm.sv */
// Pipelined 3-vector normalizer: magnitude scaling, sum of squares, digit
// recurrence square root and per-component restoring division. Uses bao_pkg.
`timescale 1ns / 1ps
module bao_norm import bao_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  vec_type  in_vec,
   output logic     out_valid,
   output unit_type out_unit,
   output logic     out_zero
);

   // Stage 0: magnitudes and signs.
   logic                       p0_valid_ff;
   logic [2:0][MAG_W-1:0]      p0_mag_ff, p0_mag_in;
   logic [2:0]                 p0_neg_ff, p0_neg_in;
   // Stage 1: shifted magnitudes.
   logic                       p1_valid_ff;
   shv_type                    p1_sh_ff, p1_sh_in;
   logic [2:0]                 p1_neg_ff;
   logic                       p1_zero_ff, p1_zero_in;
   // Stage 2: squares.
   logic                       p2_valid_ff;
   logic [2:0][SQ_W-1:0]       p2_sqr_ff, p2_sqr_in;
   shv_type                    p2_sh_ff;
   logic [2:0]                 p2_neg_ff;
   logic                       p2_zero_ff;
   // Square root stages; index 0 holds the sum of squares.
   logic                       sq_valid_ff [0:SQ_STG];
   logic [SQ_REM_W-1:0]        sq_rem_ff   [0:SQ_STG];
   logic [SQ_REM_W-1:0]        sq_rem_in   [0:SQ_STG];
   logic [ROOT_W-1:0]          sq_root_ff  [0:SQ_STG];
   logic [ROOT_W-1:0]          sq_root_in  [0:SQ_STG];
   logic [SUM_W-1:0]           sq_bits_ff  [0:SQ_STG];
   logic [SUM_W-1:0]           sq_bits_in  [0:SQ_STG];
   shv_type                    sq_sh_ff    [0:SQ_STG];
   logic [2:0]                 sq_neg_ff   [0:SQ_STG];
   logic                       sq_zero_ff  [0:SQ_STG];
   // Division stages; index 0 holds the loaded numerators.
   logic                       d_valid_ff  [0:QUO_W];
   logic [2:0][DREM_W-1:0]     d_rem_ff    [0:QUO_W];
   logic [2:0][DREM_W-1:0]     d_rem_in    [0:QUO_W];
   logic [2:0][QUO_W-1:0]      d_low_ff    [0:QUO_W];
   logic [2:0][QUO_W-1:0]      d_low_in    [0:QUO_W];
   logic [ROOT_W-1:0]          d_r_ff      [0:QUO_W];
   logic [2:0]                 d_neg_ff    [0:QUO_W];
   logic                       d_zero_ff   [0:QUO_W];
   // Output register.
   logic                       o_valid_ff;
   unit_type                   o_unit_ff, o_unit_in;
   logic                       o_zero_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p0_neg_in[i] = in_vec[i][VEC_W-1];
         p0_mag_in[i] = p0_neg_in[i] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
      end
   end

   always_comb begin
      logic [MAG_W-1:0] orv;
      logic [POS_W-1:0] shift;
      orv        = p0_mag_ff[0] | p0_mag_ff[1] | p0_mag_ff[2];
      shift      = POS_W'(NORM_BIT) - lead_pos(orv);
      p1_zero_in = (orv == '0);
      for (int i = 0; i < 3; i++) begin
         p1_sh_in[i] = SH_W'(p0_mag_ff[i]) << shift;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p2_sqr_in[i] = SQ_W'(p1_sh_ff[i]) * SQ_W'(p1_sh_ff[i]);
      end
   end

   // Two root bits per stage.
   always_comb begin
      logic [SQ_REM_W-1:0] rem, trial;
      logic [ROOT_W-1:0]   root;
      logic [SUM_W-1:0]    bits;
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      sq_bits_in[0] = SUM_W'(p2_sqr_ff[0]) + SUM_W'(p2_sqr_ff[1]) + SUM_W'(p2_sqr_ff[2]);
      for (int k = 1; k <= SQ_STG; k++) begin
         rem  = sq_rem_ff[k-1];
         root = sq_root_ff[k-1];
         bits = sq_bits_ff[k-1];
         for (int t = 0; t < 2; t++) begin
            rem   = {rem[SQ_REM_W-3:0], bits[SUM_W-1:SUM_W-2]};
            bits  = bits << 2;
            trial = SQ_REM_W'({root, 2'b01});
            if (rem >= trial) begin
               rem  = rem - trial;
               root = {root[ROOT_W-2:0], 1'b1};
            end else begin
               root = {root[ROOT_W-2:0], 1'b0};
            end
         end
         sq_rem_in[k]  = rem;
         sq_root_in[k] = root;
         sq_bits_in[k] = bits;
      end
   end

   // Numerator is mag * 2^FRAC_BITS + r/2; its high part is already below r.
   always_comb begin
      logic [NUM_W-1:0]  num;
      logic [DREM_W-1:0] rem2;
      logic              ge;
      for (int i = 0; i < 3; i++) begin
         num = (NUM_W'(sq_sh_ff[SQ_STG][i]) << FRAC_BITS)
             + NUM_W'(sq_root_ff[SQ_STG] >> 1);
         d_rem_in[0][i] = DREM_W'(num >> QUO_W);
         d_low_in[0][i] = num[QUO_W-1:0];
      end
      for (int k = 1; k <= QUO_W; k++) begin
         for (int i = 0; i < 3; i++) begin
            rem2 = {d_rem_ff[k-1][i][DREM_W-2:0], d_low_ff[k-1][i][QUO_W-1]};
            ge   = (rem2 >= DREM_W'(d_r_ff[k-1]));
            d_rem_in[k][i] = ge ? rem2 - DREM_W'(d_r_ff[k-1]) : rem2;
            d_low_in[k][i] = {d_low_ff[k-1][i][QUO_W-2:0], ge};
         end
      end
   end

   always_comb begin
      logic [QUO_W-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = d_low_ff[QUO_W][i];
         if (q > (QUO_W'(1) << FRAC_BITS)) q = QUO_W'(1) << FRAC_BITS;
         if (d_zero_ff[QUO_W])        o_unit_in[i] = '0;
         else if (d_neg_ff[QUO_W][i]) o_unit_in[i] = UNIT_W'(-q);
         else                         o_unit_in[i] = UNIT_W'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         for (int k = 0; k <= SQ_STG; k++) sq_valid_ff[k] <= 1'b0;
         for (int k = 0; k <= QUO_W; k++) d_valid_ff[k] <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         p0_valid_ff    <= in_valid;
         p1_valid_ff    <= p0_valid_ff;
         p2_valid_ff    <= p1_valid_ff;
         sq_valid_ff[0] <= p2_valid_ff;
         for (int k = 1; k <= SQ_STG; k++) sq_valid_ff[k] <= sq_valid_ff[k-1];
         d_valid_ff[0]  <= sq_valid_ff[SQ_STG];
         for (int k = 1; k <= QUO_W; k++) d_valid_ff[k] <= d_valid_ff[k-1];
         o_valid_ff     <= d_valid_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_mag_ff <= p0_mag_in;
         p0_neg_ff <= p0_neg_in;
         p1_sh_ff   <= p1_sh_in;
         p1_neg_ff  <= p0_neg_ff;
         p1_zero_ff <= p1_zero_in;
         p2_sqr_ff  <= p2_sqr_in;
         p2_sh_ff   <= p1_sh_ff;
         p2_neg_ff  <= p1_neg_ff;
         p2_zero_ff <= p1_zero_ff;
         sq_sh_ff[0]   <= p2_sh_ff;
         sq_neg_ff[0]  <= p2_neg_ff;
         sq_zero_ff[0] <= p2_zero_ff;
         for (int k = 0; k <= SQ_STG; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            sq_bits_ff[k] <= sq_bits_in[k];
         end
         for (int k = 1; k <= SQ_STG; k++) begin
            sq_sh_ff[k]   <= sq_sh_ff[k-1];
            sq_neg_ff[k]  <= sq_neg_ff[k-1];
            sq_zero_ff[k] <= sq_zero_ff[k-1];
         end
         d_r_ff[0]    <= sq_root_ff[SQ_STG];
         d_neg_ff[0]  <= sq_neg_ff[SQ_STG];
         d_zero_ff[0] <= sq_zero_ff[SQ_STG];
         for (int k = 0; k <= QUO_W; k++) begin
            d_rem_ff[k] <= d_rem_in[k];
            d_low_ff[k] <= d_low_in[k];
         end
         for (int k = 1; k <= QUO_W; k++) begin
            d_r_ff[k]    <= d_r_ff[k-1];
            d_neg_ff[k]  <= d_neg_ff[k-1];
            d_zero_ff[k] <= d_zero_ff[k-1];
         end
         o_unit_ff <= o_unit_in;
         o_zero_ff <= d_zero_ff[QUO_W];
      end
   end

   assign out_valid = o_valid_ff;
   assign out_unit  = o_unit_ff;
   assign out_zero  = o_zero_ff;

endmodule

/* rtl/core/box_axis_orthonormalize_core.sv */
// Box axis orthonormalizer: one frame per cycle while the rsp side takes results.
// Throughput is set by the fully pipelined normalizers (square root and divider);
// the whole pipeline holds while a result waits on the rsp side.
// Reset (synchronous, active high) clears only the valid bits; no state else.
// Depends on bao_pkg and bao_norm.
`timescale 1ns / 1ps
module box_axis_orthonormalize_core import bao_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
   input  logic [215:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // unit_first_x/y/z, unit_second_x/y/z, unit_third_x/y/z, two zero pad bits
   output logic [199:0] rsp_tdata,
   // degenerate
   output logic         rsp_tuser
);

   // The pipeline moves as a whole whenever the output register is free or
   // its transfer completes this cycle.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   in_vec_type a1, a2, a3;
   vec_type    n1_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a1[i]    = req_tdata[i*IN_W +: IN_W];
         a2[i]    = req_tdata[(3+i)*IN_W +: IN_W];
         a3[i]    = req_tdata[(6+i)*IN_W +: IN_W];
         n1_in[i] = ext_in(a1[i]);
      end
   end

   logic     n1_valid, n2_valid, n3_valid;
   unit_type n1_unit, n2_unit, n3_unit;
   logic     n1_zero, n2_zero, n3_zero;

   // Cross product units: index 0 builds the third axis, index 1 the second.
   logic    x_valid [2];
   vec_type x_a [2];
   vec_type x_b [2];
   vec_type x_p [2];
   logic    xo_valid [2];
   vec_type xo_vec [2];

   // Side data travels beside the arithmetic, one entry per pipeline stage.
   side_type side_ff [0:SIDE_DEPTH-1];
   side_type side_in [0:SIDE_DEPTH-1];

   always_comb begin
      side_in[0].a2  = a2;
      side_in[0].a3  = a3;
      side_in[0].u1  = '0;
      side_in[0].u3  = '0;
      side_in[0].deg = 1'b0;
      for (int i = 1; i < SIDE_DEPTH; i++) side_in[i] = side_ff[i-1];
      // The first unit axis joins the side data as it leaves its normalizer.
      side_in[NORM_LAT].u1  = n1_unit;
      side_in[NORM_LAT].deg = n1_zero;
      side_in[2*NORM_LAT+XLAT].u3  = n3_unit;
      side_in[2*NORM_LAT+XLAT].deg = side_ff[2*NORM_LAT+XLAT-1].deg | n3_zero;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < SIDE_DEPTH; i++) side_ff[i] <= side_in[i];
      end
   end

   bao_norm u_norm_first (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_vec    (n1_in),
      .out_valid (n1_valid),
      .out_unit  (n1_unit),
      .out_zero  (n1_zero)
   );

   always_comb begin
      x_valid[0] = n1_valid;
      x_valid[1] = n3_valid;
      for (int i = 0; i < 3; i++) begin
         x_a[0][i] = ext_unit(n1_unit[i]);
         x_b[0][i] = ext_in(side_ff[NORM_LAT-1].a2[i]);
         x_p[0][i] = ext_in(side_ff[NORM_LAT-1].a3[i]);
         x_a[1][i] = ext_unit(side_ff[2*NORM_LAT+XLAT-1].u1[i]);
         x_b[1][i] = ext_unit(n3_unit[i]);
         x_p[1][i] = ext_in(side_ff[2*NORM_LAT+XLAT-1].a2[i]);
      end
   end

   // Each cross unit: products, floored difference, dot products with the
   // reference axis, then a sign flip when that dot is negative.
   for (genvar k = 0; k < 2; k++) begin : g_cross
      logic                           v1_ff, v2_ff, v3_ff, v4_ff;
      logic signed [5:0][PROD_W-1:0]  m_ff, m_in;
      vec_type                        p1_ff, p2_ff;
      vec_type                        c2_ff, c2_in, c3_ff, c4_ff, c4_in;
      logic signed [2:0][PROD_W-1:0]  dp_ff, dp_in;

      always_comb begin
         m_in[0] = $signed(x_a[k][1]) * $signed(x_b[k][2]);
         m_in[1] = $signed(x_a[k][2]) * $signed(x_b[k][1]);
         m_in[2] = $signed(x_a[k][2]) * $signed(x_b[k][0]);
         m_in[3] = $signed(x_a[k][0]) * $signed(x_b[k][2]);
         m_in[4] = $signed(x_a[k][0]) * $signed(x_b[k][1]);
         m_in[5] = $signed(x_a[k][1]) * $signed(x_b[k][0]);
      end

      always_comb begin
         logic signed [PROD_W:0] diff;
         for (int j = 0; j < 3; j++) begin
            diff     = $signed(m_ff[2*j]) - $signed(m_ff[2*j+1]);
            c2_in[j] = VEC_W'(diff >>> FRAC_BITS);
         end
      end

      always_comb begin
         for (int j = 0; j < 3; j++) begin
            dp_in[j] = $signed(c2_ff[j]) * $signed(p2_ff[j]);
         end
      end

      always_comb begin
         logic signed [DOT_W-1:0] dot;
         dot = $signed(dp_ff[0]) + $signed(dp_ff[1]) + $signed(dp_ff[2]);
         for (int j = 0; j < 3; j++) begin
            c4_in[j] = dot[DOT_W-1] ? VEC_W'(-c3_ff[j]) : c3_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v1_ff <= 1'b0;
            v2_ff <= 1'b0;
            v3_ff <= 1'b0;
            v4_ff <= 1'b0;
         end else if (advance) begin
            v1_ff <= x_valid[k];
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            m_ff  <= m_in;
            p1_ff <= x_p[k];
            c2_ff <= c2_in;
            p2_ff <= p1_ff;
            dp_ff <= dp_in;
            c3_ff <= c2_ff;
            c4_ff <= c4_in;
         end
      end

      assign xo_valid[k] = v4_ff;
      assign xo_vec[k]   = c4_ff;
   end

   bao_norm u_norm_third (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (xo_valid[0]),
      .in_vec    (xo_vec[0]),
      .out_valid (n3_valid),
      .out_unit  (n3_unit),
      .out_zero  (n3_zero)
   );

   bao_norm u_norm_second (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (xo_valid[1]),
      .in_vec    (xo_vec[1]),
      .out_valid (n2_valid),
      .out_unit  (n2_unit),
      .out_zero  (n2_zero)
   );

   // The second normalizer's output register is the result register.
   assign rsp_tvalid = n2_valid;
   assign rsp_tuser  = side_ff[SIDE_DEPTH-1].deg | n2_zero;
   assign rsp_tdata  = {2'b00, side_ff[SIDE_DEPTH-1].u3, n2_unit, side_ff[SIDE_DEPTH-1].u1};

endmodule
